// ===== rtl/safs_pkg.sv =====
// Package for the sprite animation frame sequencer: action and register codes,
// layout widths, microcode word format and the microcode program ROM.
// No dependencies; every other file of the block imports it.
package safs_pkg;

  // Action codes of an input request.
  localparam logic [1:0] ACT_TICK     = 2'd0;
  localparam logic [1:0] ACT_PLAY     = 2'd1;
  localparam logic [1:0] ACT_SET_ONE  = 2'd2;
  localparam logic [1:0] ACT_SET_ALL  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLAY       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED       = 3'd6;

  // Fixed field widths.
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned TICKS_W    = 24;
  localparam int unsigned TEXEL_W    = 16;
  localparam int unsigned FCOUNT_W   = 7;
  localparam int unsigned FDIM_W     = 12;
  localparam int unsigned GAP_W      = 8;
  localparam int unsigned PITCH_W    = 13;

  // Shared serial divider: one quotient bit per cycle.
  localparam int unsigned DIV_W      = 13;
  localparam int unsigned DIV_CNT_W  = 4;

  // Microcode.
  localparam int unsigned STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_ALL_INIT,
    OP_ALL_WRITE,
    OP_INC,
    OP_STOP,
    OP_FRAME_INC,
    OP_FRAME_DEC,
    OP_RESTART,
    OP_PLAY,
    OP_LOAD,
    OP_SET1,
    OP_ROW_START,
    OP_ROW_SAVE,
    OP_FRM_START,
    OP_MUL_X,
    OP_MUL_Y,
    OP_SAT_Y,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_ACT_TICK,
    C_ACT_PLAY,
    C_ACT_SET1,
    C_SWEEP_MORE,
    C_TICK_IDLE,
    C_INC_HOLDS,
    C_CAN_FWD,
    C_CAN_BACK,
    C_REPLAY,
    C_PLAY_SKIP,
    C_LAYOUT_CLEAN,
    C_DIV_BUSY,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  // Status seen by the sequencer's jump conditions.
  typedef struct packed {
    logic no_input;
    logic act_tick;
    logic act_play;
    logic act_set1;
    logic sweep_more;
    logic tick_idle;
    logic inc_holds;
    logic can_fwd;
    logic can_back;
    logic replay;
    logic play_skip;
    logic layout_clean;
    logic div_busy;
    logic out_free;
  } flags_t;

  // Program addresses.
  localparam step_t S_FETCH      = 5'd0;
  localparam step_t S_DISP_TICK  = 5'd1;
  localparam step_t S_DISP_PLAY  = 5'd2;
  localparam step_t S_DISP_SET1  = 5'd3;
  localparam step_t S_ALL_INIT   = 5'd4;
  localparam step_t S_ALL_WR     = 5'd5;
  localparam step_t S_ALL_END    = 5'd6;
  localparam step_t S_TICK       = 5'd7;
  localparam step_t S_TICK_INC   = 5'd8;
  localparam step_t S_CHK_FWD    = 5'd9;
  localparam step_t S_CHK_BACK   = 5'd10;
  localparam step_t S_CHK_REPLAY = 5'd11;
  localparam step_t S_STOP       = 5'd12;
  localparam step_t S_STEP_FWD   = 5'd13;
  localparam step_t S_STEP_BACK  = 5'd14;
  localparam step_t S_RESTART    = 5'd15;
  localparam step_t S_PLAY       = 5'd16;
  localparam step_t S_PLAY_GO    = 5'd17;
  localparam step_t S_LOAD       = 5'd18;
  localparam step_t S_LAYOUT     = 5'd19;
  localparam step_t S_ROW_WAIT   = 5'd20;
  localparam step_t S_ROW_SAVE   = 5'd21;
  localparam step_t S_FRM_START  = 5'd22;
  localparam step_t S_FRM_WAIT   = 5'd23;
  localparam step_t S_MUL_X      = 5'd24;
  localparam step_t S_MUL_Y      = 5'd25;
  localparam step_t S_SAT_Y      = 5'd26;
  localparam step_t S_EMIT       = 5'd27;
  localparam step_t S_EMIT_RETRY = 5'd28;
  localparam step_t S_SET1       = 5'd29;

  // Control store. A word runs its op; when its condition holds the next step is
  // the target, otherwise the following address.
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    unique case (s)
      S_FETCH:      w = '{OP_LATCH,     C_NO_INPUT,     S_FETCH};
      S_DISP_TICK:  w = '{OP_NOP,       C_ACT_TICK,     S_TICK};
      S_DISP_PLAY:  w = '{OP_NOP,       C_ACT_PLAY,     S_PLAY};
      S_DISP_SET1:  w = '{OP_NOP,       C_ACT_SET1,     S_SET1};
      S_ALL_INIT:   w = '{OP_ALL_INIT,  C_NEVER,        S_FETCH};
      S_ALL_WR:     w = '{OP_ALL_WRITE, C_SWEEP_MORE,   S_ALL_WR};
      S_ALL_END:    w = '{OP_NOP,       C_ALWAYS,       S_LAYOUT};
      S_TICK:       w = '{OP_NOP,       C_TICK_IDLE,    S_LAYOUT};
      S_TICK_INC:   w = '{OP_INC,       C_INC_HOLDS,    S_LAYOUT};
      S_CHK_FWD:    w = '{OP_NOP,       C_CAN_FWD,      S_STEP_FWD};
      S_CHK_BACK:   w = '{OP_NOP,       C_CAN_BACK,     S_STEP_BACK};
      S_CHK_REPLAY: w = '{OP_NOP,       C_REPLAY,       S_RESTART};
      S_STOP:       w = '{OP_STOP,      C_ALWAYS,       S_LAYOUT};
      S_STEP_FWD:   w = '{OP_FRAME_INC, C_ALWAYS,       S_LOAD};
      S_STEP_BACK:  w = '{OP_FRAME_DEC, C_ALWAYS,       S_LOAD};
      S_RESTART:    w = '{OP_RESTART,   C_ALWAYS,       S_LOAD};
      S_PLAY:       w = '{OP_NOP,       C_PLAY_SKIP,    S_LAYOUT};
      S_PLAY_GO:    w = '{OP_PLAY,      C_NEVER,        S_FETCH};
      S_LOAD:       w = '{OP_LOAD,      C_NEVER,        S_FETCH};
      S_LAYOUT:     w = '{OP_ROW_START, C_LAYOUT_CLEAN, S_FRM_START};
      S_ROW_WAIT:   w = '{OP_NOP,       C_DIV_BUSY,     S_ROW_WAIT};
      S_ROW_SAVE:   w = '{OP_ROW_SAVE,  C_NEVER,        S_FETCH};
      S_FRM_START:  w = '{OP_FRM_START, C_NEVER,        S_FETCH};
      S_FRM_WAIT:   w = '{OP_NOP,       C_DIV_BUSY,     S_FRM_WAIT};
      S_MUL_X:      w = '{OP_MUL_X,     C_NEVER,        S_FETCH};
      S_MUL_Y:      w = '{OP_MUL_Y,     C_NEVER,        S_FETCH};
      S_SAT_Y:      w = '{OP_SAT_Y,     C_NEVER,        S_FETCH};
      S_EMIT:       w = '{OP_EMIT,      C_OUT_FREE,     S_FETCH};
      S_EMIT_RETRY: w = '{OP_NOP,       C_ALWAYS,       S_EMIT};
      S_SET1:       w = '{OP_SET1,      C_ALWAYS,       S_LAYOUT};
      default:      w = '{OP_NOP,       C_ALWAYS,       S_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/safs_div.sv =====
// Restoring serial divider of the frame sequencer, one quotient bit per cycle.
// Depends on safs_pkg for the operand width and the step counter width.
module safs_div import safs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quotient_o,
  output logic [DIV_W-1:0] remainder_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     dvs_q, dvs_d;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = DIV_CNT_W'(DIV_W);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      // A negative trial difference leaves the shifted remainder in place.
      rem_d = diff[DIV_W] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ~diff[DIV_W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== rtl/safs_useq.sv =====
// Microcode sequencer of the frame sequencer: step counter, control store and
// jump condition select. Depends on safs_pkg for the program and word format.
module safs_useq import safs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output uword_t uword_o
);

  step_t  step_q, step_d;
  uword_t uw;
  logic   take;

  assign uw = ucode_rom(step_q);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NO_INPUT:     take = flags_i.no_input;
      C_ACT_TICK:     take = flags_i.act_tick;
      C_ACT_PLAY:     take = flags_i.act_play;
      C_ACT_SET1:     take = flags_i.act_set1;
      C_SWEEP_MORE:   take = flags_i.sweep_more;
      C_TICK_IDLE:    take = flags_i.tick_idle;
      C_INC_HOLDS:    take = flags_i.inc_holds;
      C_CAN_FWD:      take = flags_i.can_fwd;
      C_CAN_BACK:     take = flags_i.can_back;
      C_REPLAY:       take = flags_i.replay;
      C_PLAY_SKIP:    take = flags_i.play_skip;
      C_LAYOUT_CLEAN: take = flags_i.layout_clean;
      C_DIV_BUSY:     take = flags_i.div_busy;
      C_OUT_FREE:     take = flags_i.out_free;
      default:        take = 1'b0;
    endcase
    step_d = take ? uw.target : step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign uword_o = uw;

endmodule

// ===== rtl/sprite_animation_frame_sequencer_top.sv =====
// Top level of the sprite animation frame sequencer: interval memory, state,
// layout datapath and output register. Depends on safs_pkg, safs_useq, safs_div.
//
//   Port group   Handshake               Contents
//   -----------  ----------------------  -----------------------------------------
//   request in   in_valid_i / in_ready_o action, direction, force, index, interval
//   result out   out_valid_o/out_ready_i play flag, frame, texel x/y, first/last
//   config       cfg_we_i (no wait)      register index and data
//
// Apart from a set-all request, which also writes every entry of the interval memory,
// a request spends most of its time from accept to result in the serial divider that
// splits the frame into row and column. The first request after a register write also
// runs the divider for the frames per row. One request is in work at a time; a stalled
// result is held while the next request runs, whose result waits until the held one is taken.
// Reset is asynchronous and active low; interval memory contents are not reset.
module sprite_animation_frame_sequencer_top import safs_pkg::*; #(
  parameter int unsigned MAX_FRAMES    = 64,
  parameter int unsigned INTERVAL_BITS = 24,
  parameter int unsigned COORD_BITS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic                  forward_i,
  input  logic                  force_restart_i,
  input  logic [IDX_W-1:0]      frame_index_i,
  input  logic [TICKS_W-1:0]    interval_ticks_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  playing_o,
  output logic [IDX_W-1:0]      current_frame_o,
  output logic [TEXEL_W-1:0]    texel_x_o,
  output logic [TEXEL_W-1:0]    texel_y_o,
  output logic                  at_first_o,
  output logic                  at_last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FW     = $clog2(MAX_FRAMES);
  localparam int unsigned IB     = INTERVAL_BITS;
  localparam int unsigned CW     = (FW + 1 > FCOUNT_W) ? FW + 1 : FCOUNT_W;
  localparam int unsigned PROD_W = PITCH_W + FW;
  localparam int unsigned SAT_W  = (PROD_W > COORD_BITS) ? PROD_W : COORD_BITS;
  localparam logic [SAT_W-1:0] COORD_MAX = SAT_W'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [CW-1:0]    MAX_CNT   = CW'(MAX_FRAMES);

  function automatic logic [TEXEL_W-1:0] sat_coord(input logic [PROD_W-1:0] p);
    logic [SAT_W-1:0] v;
    v = SAT_W'(p);
    if (v > COORD_MAX) v = COORD_MAX;
    return TEXEL_W'(v);
  endfunction

  // Sequencer.
  uword_t uw;
  flags_t flags;

  // Configuration registers.
  logic [FCOUNT_W-1:0] fcount_q;
  logic [FDIM_W-1:0]   fwidth_q;
  logic [FDIM_W-1:0]   fheight_q;
  logic [GAP_W-1:0]    gap_q;
  logic [PITCH_W-1:0]  sheet_q;
  logic                replay_q;
  logic                paused_q;
  logic                dirty_q, dirty_d;

  // Animation state.
  logic [FW-1:0] frame_q, frame_d;
  logic          run_q, run_d;
  logic          dir_q, dir_d;
  logic [IB-1:0] elapsed_q, elapsed_d;
  logic [IB-1:0] ivl_now_q, ivl_now_d;
  logic [FW-1:0] sweep_q, sweep_d;

  // Latched request.
  logic [ACTION_W-1:0] act_q;
  logic                fwd_in_q;
  logic                force_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IB-1:0]       ivl_in_q;

  // Layout datapath.
  logic [PITCH_W-1:0] per_row_q, per_row_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [TEXEL_W-1:0] texx_q, texx_d;
  logic [TEXEL_W-1:0] texy_q, texy_d;
  logic [PITCH_W-1:0] pitch_x, pitch_y;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend, div_divisor, div_quo, div_rem;
  logic               div_busy;

  // Interval memory.
  logic [IB-1:0] mem [MAX_FRAMES];
  logic          mem_we;
  logic [FW-1:0] mem_waddr;
  logic [IB-1:0] mem_wdata;
  logic [IB-1:0] rdata_q;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic               playing_q;
  logic [IDX_W-1:0]   cur_q;
  logic [TEXEL_W-1:0] out_x_q, out_y_q;
  logic               first_q, last_q;

  logic [CW-1:0] cnt_eff;
  logic [FW-1:0] last_frame;
  logic [IB-1:0] elapsed_inc;
  logic          in_accept;
  logic          out_free;
  logic          idx_ok;
  logic          idx_is_now;

  safs_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw)
  );

  safs_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // A frame count of zero acts as one; counts above the memory depth clamp to it.
  always_comb begin
    cnt_eff = CW'(fcount_q);
    if (cnt_eff == '0) cnt_eff = CW'(1);
    if (cnt_eff > MAX_CNT) cnt_eff = MAX_CNT;
    last_frame = FW'(cnt_eff - CW'(1));
  end

  assign pitch_x     = PITCH_W'(fwidth_q) + PITCH_W'(gap_q);
  assign pitch_y     = PITCH_W'(fheight_q) + PITCH_W'(gap_q);
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign in_ready_o  = (uw.op == OP_LATCH);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign idx_ok      = (32'(idx_q) < 32'(MAX_FRAMES));
  assign idx_is_now  = (32'(frame_q) == 32'(idx_q));

  always_comb begin
    flags.no_input     = !in_valid_i;
    flags.act_tick     = (act_q == ACT_TICK);
    flags.act_play     = (act_q == ACT_PLAY);
    flags.act_set1     = (act_q == ACT_SET_ONE);
    flags.sweep_more   = (sweep_q != FW'(MAX_FRAMES - 1));
    flags.tick_idle    = !run_q || paused_q;
    flags.inc_holds    = (elapsed_inc < ivl_now_q);
    flags.can_fwd      = dir_q && (frame_q < last_frame);
    flags.can_back     = !dir_q && (frame_q != '0);
    flags.replay       = replay_q;
    flags.play_skip    = run_q && !force_q;
    flags.layout_clean = !dirty_q;
    flags.div_busy     = div_busy;
    flags.out_free     = out_free;
  end

  // Datapath driven by the current control word.
  always_comb begin
    frame_d      = frame_q;
    run_d        = run_q;
    dir_d        = dir_q;
    elapsed_d    = elapsed_q;
    ivl_now_d    = ivl_now_q;
    sweep_d      = sweep_q;
    dirty_d      = dirty_q;
    per_row_d    = per_row_q;
    prod_d       = prod_q;
    texx_d       = texx_q;
    texy_d       = texy_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_we       = 1'b0;
    mem_waddr    = sweep_q;
    mem_wdata    = ivl_in_q;
    div_start    = 1'b0;
    div_dividend = sheet_q;
    div_divisor  = pitch_x;
    case (uw.op)
      OP_ALL_INIT: begin
        sweep_d   = '0;
        ivl_now_d = ivl_in_q;
        elapsed_d = '0;
      end
      OP_ALL_WRITE: begin
        mem_we  = 1'b1;
        sweep_d = sweep_q + 1'b1;
      end
      OP_INC: begin
        // The counter clears on expiry; a step, a restart or a stop follows.
        elapsed_d = flags.inc_holds ? elapsed_inc : '0;
      end
      OP_STOP: begin
        run_d = 1'b0;
      end
      OP_FRAME_INC: begin
        frame_d = frame_q + 1'b1;
      end
      OP_FRAME_DEC: begin
        frame_d = frame_q - 1'b1;
      end
      OP_RESTART: begin
        frame_d = dir_q ? '0 : last_frame;
      end
      OP_PLAY: begin
        run_d   = 1'b1;
        dir_d   = fwd_in_q;
        frame_d = fwd_in_q ? '0 : last_frame;
      end
      OP_LOAD: begin
        ivl_now_d = rdata_q;
        elapsed_d = '0;
      end
      OP_SET1: begin
        mem_we    = idx_ok;
        mem_waddr = FW'(idx_q);
        if (idx_ok && idx_is_now) begin
          ivl_now_d = ivl_in_q;
          elapsed_d = '0;
        end
      end
      OP_ROW_START: begin
        div_start = dirty_q;
      end
      OP_ROW_SAVE: begin
        per_row_d = (pitch_x == '0 || div_quo == '0) ? PITCH_W'(1) : div_quo;
        dirty_d   = 1'b0;
      end
      OP_FRM_START: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(frame_q);
        div_divisor  = per_row_q;
      end
      OP_MUL_X: begin
        prod_d = PROD_W'(pitch_x) * PROD_W'(div_rem[FW-1:0]);
      end
      OP_MUL_Y: begin
        texx_d = sat_coord(prod_q);
        prod_d = PROD_W'(pitch_y) * PROD_W'(div_quo[FW-1:0]);
      end
      OP_SAT_Y: begin
        texy_d = sat_coord(prod_q);
      end
      OP_EMIT: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
    // Any register write invalidates the cached frames per row.
    if (cfg_we_i) dirty_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q    <= FCOUNT_W'(1);
      fwidth_q    <= FDIM_W'(16);
      fheight_q   <= FDIM_W'(16);
      gap_q       <= '0;
      sheet_q     <= PITCH_W'(256);
      replay_q    <= 1'b0;
      paused_q    <= 1'b0;
      dirty_q     <= 1'b1;
      frame_q     <= '0;
      run_q       <= 1'b0;
      dir_q       <= 1'b0;
      elapsed_q   <= '0;
      ivl_now_q   <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_COUNT:  fcount_q  <= cfg_data_i[FCOUNT_W-1:0];
          CFG_FRAME_WIDTH:  fwidth_q  <= cfg_data_i[FDIM_W-1:0];
          CFG_FRAME_HEIGHT: fheight_q <= cfg_data_i[FDIM_W-1:0];
          CFG_PIXEL_GAP:    gap_q     <= cfg_data_i[GAP_W-1:0];
          CFG_SHEET_WIDTH:  sheet_q   <= cfg_data_i[PITCH_W-1:0];
          CFG_REPLAY:       replay_q  <= cfg_data_i[0];
          CFG_PAUSED:       paused_q  <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      dirty_q     <= dirty_d;
      frame_q     <= frame_d;
      run_q       <= run_d;
      dir_q       <= dir_d;
      elapsed_q   <= elapsed_d;
      ivl_now_q   <= ivl_now_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q    <= action_i;
      fwd_in_q <= forward_i;
      force_q  <= force_restart_i;
      idx_q    <= frame_index_i;
      ivl_in_q <= IB'(interval_ticks_i);
    end
    per_row_q <= per_row_d;
    prod_q    <= prod_d;
    texx_q    <= texx_d;
    texy_q    <= texy_d;
    if (uw.op == OP_EMIT && out_free) begin
      playing_q <= run_q;
      cur_q     <= IDX_W'(frame_q);
      out_x_q   <= texx_q;
      out_y_q   <= texy_q;
      first_q   <= (frame_q == '0);
      last_q    <= (frame_q == last_frame);
    end
  end

  // The read address follows the next frame, so the interval is registered together
  // with the new value of the frame register.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[frame_d];
  end

  assign out_valid_o     = out_valid_q;
  assign playing_o       = playing_q;
  assign current_frame_o = cur_q;
  assign texel_x_o       = out_x_q;
  assign texel_y_o       = out_y_q;
  assign at_first_o      = first_q;
  assign at_last_o       = last_q;

endmodule

// ===== rtl/safs_chk.sv =====
// Port-level checker of the sprite animation frame sequencer and its bind to
// the top level. Depends on safs_pkg for the field widths.
module safs_chk import safs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [ACTION_W-1:0]   action_i,
  input logic                  forward_i,
  input logic                  force_restart_i,
  input logic [IDX_W-1:0]      frame_index_i,
  input logic [TICKS_W-1:0]    interval_ticks_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  playing_o,
  input logic [IDX_W-1:0]      current_frame_o,
  input logic [TEXEL_W-1:0]    texel_x_o,
  input logic [TEXEL_W-1:0]    texel_y_o,
  input logic                  at_first_o,
  input logic                  at_last_o,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // A result that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(current_frame_o)
      && $stable(texel_x_o) && $stable(texel_y_o) && $stable(playing_o))
    else $error("result changed while stalled");

  // Only one request is in work: an accept is followed by a busy cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in work");

  // A result cannot appear in the cycle right after a request is accepted.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // The first-frame flag is set only on frame zero.
  a_first_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_first_o |-> current_frame_o == '0)
    else $error("first-frame flag set on a nonzero frame");

endmodule

bind sprite_animation_frame_sequencer_top safs_chk u_safs_chk (.*);

// ===== sim/sprite_animation_frame_sequencer_top_test.sv =====
// Self-checking testbench for sprite_animation_frame_sequencer_top: drives
// requests and register writes, and checks every result against its own predictor.
// Depends on safs_pkg and the RTL of the block; reads no files.
module sprite_animation_frame_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import safs_pkg::*;

  localparam int unsigned FRAMES = 64;

  typedef struct packed {
    logic                playing;
    logic [IDX_W-1:0]    frame;
    logic [TEXEL_W-1:0]  texel_x;
    logic [TEXEL_W-1:0]  texel_y;
    logic                at_first;
    logic                at_last;
  } frame_view_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ACTION_W-1:0]   action_i;
  logic                  forward_i;
  logic                  force_restart_i;
  logic [IDX_W-1:0]      frame_index_i;
  logic [TICKS_W-1:0]    interval_ticks_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  playing_o;
  logic [IDX_W-1:0]      current_frame_o;
  logic [TEXEL_W-1:0]    texel_x_o;
  logic [TEXEL_W-1:0]    texel_y_o;
  logic                  at_first_o;
  logic                  at_last_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sprite_animation_frame_sequencer_top u_dut (.*);

  // Predicted sequencer state and register copies.
  logic [TICKS_W-1:0]  interval_mem [FRAMES];
  logic [IDX_W-1:0]    shown_frame = '0;
  logic                running = 1'b0;
  logic                heading_forward = 1'b0;
  logic [TICKS_W-1:0]  ticks_elapsed = '0;
  logic [TICKS_W-1:0]  ticks_needed = '0;
  logic [FCOUNT_W-1:0] cfg_frame_count = 7'd1;
  logic [FDIM_W-1:0]   cfg_frame_width = 12'd16;
  logic [FDIM_W-1:0]   cfg_frame_height = 12'd16;
  logic [GAP_W-1:0]    cfg_pixel_gap = '0;
  logic [PITCH_W-1:0]  cfg_sheet_width = 13'd256;
  logic                cfg_replay = 1'b0;
  logic                cfg_paused = 1'b0;

  frame_view_t pending_views[$];
  bit          sender_idles = 1'b1;
  bit          receiver_stalls = 1'b1;
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned layouts_used = 0;
  int unsigned action_seen [4] = '{0, 0, 0, 0};

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [IDX_W-1:0] last_shown_frame();
    if (cfg_frame_count == 0) return '0;
    if (cfg_frame_count > FRAMES) return IDX_W'(FRAMES - 1);
    return IDX_W'(cfg_frame_count - 1);
  endfunction

  function automatic void show_frame(input logic [IDX_W-1:0] f);
    shown_frame = f;
    ticks_needed = interval_mem[f];
    ticks_elapsed = '0;
  endfunction

  function automatic void start_run(input logic fwd);
    running = 1'b1;
    heading_forward = fwd;
    show_frame(fwd ? IDX_W'(0) : last_shown_frame());
  endfunction

  // Applies one request to the predicted state and returns the frame view it yields.
  function automatic frame_view_t advance_sequencer(input logic [ACTION_W-1:0] action,
                                                    input logic fwd, input logic force_restart,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [TICKS_W-1:0] ticks);
    frame_view_t v;
    int unsigned pitch_x, pitch_y, per_row, tx, ty;
    logic [IDX_W-1:0] last;
    last = last_shown_frame();
    case (action)
      ACT_TICK: if (running && !cfg_paused) begin
        if (ticks_elapsed != '1) ticks_elapsed++;
        // An interval of zero is already reached after the increment.
        if (ticks_elapsed >= ticks_needed) begin
          ticks_elapsed = '0;
          if (heading_forward && shown_frame < last) show_frame(shown_frame + 1'b1);
          else if (!heading_forward && shown_frame > 0) show_frame(shown_frame - 1'b1);
          else if (cfg_replay) start_run(heading_forward);
          else running = 1'b0;
        end
      end
      ACT_PLAY: if (!running || force_restart) start_run(fwd);
      ACT_SET_ONE: begin
        interval_mem[idx] = ticks;
        if (shown_frame == idx) begin
          ticks_needed = ticks;
          ticks_elapsed = '0;
        end
      end
      default: begin
        foreach (interval_mem[i]) interval_mem[i] = ticks;
        ticks_needed = ticks;
        ticks_elapsed = '0;
      end
    endcase
    pitch_x = cfg_frame_width + cfg_pixel_gap;
    pitch_y = cfg_frame_height + cfg_pixel_gap;
    per_row = (pitch_x != 0) ? cfg_sheet_width / pitch_x : 1;
    if (per_row == 0) per_row = 1;
    tx = pitch_x * (shown_frame % per_row);
    ty = pitch_y * (shown_frame / per_row);
    v.playing  = running;
    v.frame    = shown_frame;
    v.texel_x  = (tx > 32'hFFFF) ? 16'hFFFF : tx[TEXEL_W-1:0];
    v.texel_y  = (ty > 32'hFFFF) ? 16'hFFFF : ty[TEXEL_W-1:0];
    v.at_first = (shown_frame == 0);
    v.at_last  = (shown_frame == last);
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
  endtask

  task automatic send_request(input logic [ACTION_W-1:0] action, input logic fwd,
                              input logic force_restart, input logic [IDX_W-1:0] idx,
                              input logic [TICKS_W-1:0] ticks);
    int unsigned gap;
    frame_view_t view;
    gap = sender_idles ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= action;
    forward_i        <= fwd;
    force_restart_i  <= force_restart;
    frame_index_i    <= idx;
    interval_ticks_i <= ticks;
    do @(posedge clk_i); while (!in_ready_o);
    view = advance_sequencer(action, fwd, force_restart, idx, ticks);
    pending_views = {pending_views, view};
    requests_sent++;
    action_seen[action]++;
  endtask

  // Holds off new requests until every outstanding result has been taken.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FRAME_COUNT:  cfg_frame_count = data[FCOUNT_W-1:0];
      CFG_FRAME_WIDTH:  cfg_frame_width = data[FDIM_W-1:0];
      CFG_FRAME_HEIGHT: cfg_frame_height = data[FDIM_W-1:0];
      CFG_PIXEL_GAP:    cfg_pixel_gap = data[GAP_W-1:0];
      CFG_SHEET_WIDTH:  cfg_sheet_width = data[PITCH_W-1:0];
      CFG_REPLAY:       cfg_replay = data[0];
      CFG_PAUSED:       cfg_paused = data[0];
      default: ;
    endcase
  endtask

  // Bits above each register's width carry noise, which the block must drop.
  task automatic apply_layout(input int unsigned count, input int unsigned width,
                              input int unsigned height, input int unsigned gap,
                              input int unsigned sheet, input bit replay, input bit hold);
    logic [31:0] noise;
    noise = $urandom();
    drain_requests();
    write_register(CFG_FRAME_COUNT, {noise[12:7], count[6:0]});
    write_register(CFG_FRAME_WIDTH, {noise[12], width[11:0]});
    write_register(CFG_FRAME_HEIGHT, {noise[11], height[11:0]});
    write_register(CFG_PIXEL_GAP, {noise[12:8], gap[7:0]});
    write_register(CFG_SHEET_WIDTH, sheet[12:0]);
    write_register(CFG_REPLAY, {noise[24:13], replay});
    write_register(CFG_PAUSED, {noise[31:20], hold});
    layouts_used++;
  endtask

  task automatic test_interval_writes();
    apply_layout(4, 16, 8, 2, 40, 1'b0, 1'b0);
    // The table is only read after the set-all below has filled it.
    send_request(ACT_TICK, 1'b0, 1'b0, 6'd0, 24'd0);
    send_request(ACT_SET_ONE, 1'b1, 1'b1, 6'd0, 24'hFFFFFF);
    send_request(ACT_SET_ONE, 1'b0, 1'b0, 6'd63, 24'd0);
    send_request(ACT_SET_ALL, 1'b1, 1'b1, 6'h3F, 24'hFFFFFF);
    send_request(ACT_SET_ALL, 1'b0, 1'b0, 6'd0, 24'd1);
  endtask

  task automatic test_forward_run();
    send_request(ACT_PLAY, 1'b1, 1'b0, 6'd0, 24'd0);
    repeat (5) send_request(ACT_TICK, 1'b0, 1'b0, 6'd0, 24'd0);
  endtask

  task automatic test_restart_rules();
    send_request(ACT_PLAY, 1'b0, 1'b0, 6'd0, 24'd0);
    send_request(ACT_TICK, 1'b0, 1'b0, 6'd0, 24'd0);
    send_request(ACT_PLAY, 1'b1, 1'b0, 6'd0, 24'd0);
    send_request(ACT_PLAY, 1'b1, 1'b1, 6'd0, 24'd0);
    send_request(ACT_SET_ONE, 1'b0, 1'b0, 6'd0, 24'd2);
    repeat (2) send_request(ACT_TICK, 1'b0, 1'b0, 6'd0, 24'd0);
  endtask

  task automatic test_replay_and_pause();
    apply_layout(4, 16, 8, 2, 40, 1'b1, 1'b0);
    send_request(ACT_SET_ALL, 1'b0, 1'b0, 6'd0, 24'd0);
    send_request(ACT_PLAY, 1'b1, 1'b1, 6'd0, 24'd0);
    repeat (4) send_request(ACT_TICK, 1'b0, 1'b0, 6'd0, 24'd0);
    apply_layout(4, 16, 8, 2, 40, 1'b1, 1'b1);
    send_request(ACT_TICK, 1'b0, 1'b0, 6'd0, 24'd0);
    send_request(ACT_PLAY, 1'b0, 1'b1, 6'd0, 24'd0);
    send_request(ACT_TICK, 1'b0, 1'b0, 6'd0, 24'd0);
  endtask

  task automatic test_random_phases();
    int unsigned pick, count;
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    idx;
    logic [TICKS_W-1:0]  ticks;
    for (int phase = 0; phase < 19; phase++) begin
      case (phase)
        // Zero count, zero pitch and an empty sheet.
        0: apply_layout(0, 0, 4095, 0, 0, 1'b1, 1'b0);
        // Largest pitch: positions saturate.
        1: apply_layout(127, 4095, 4095, 255, 8191, 1'b1, 1'b0);
        2: apply_layout(64, 1, 1, 0, 4096, 1'b0, 1'b0);
        // Sheet narrower than one frame, ticks held.
        3: apply_layout(1, 4095, 1, 255, 1, 1'b0, 1'b1);
        default: begin
          case ($urandom_range(0, 4))
            0: count = $urandom_range(0, 1);
            1: count = $urandom_range(2, 8);
            2: count = 64;
            3: count = $urandom_range(65, 127);
            default: count = $urandom_range(1, 64);
          endcase
          apply_layout(count,
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(1, 24),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(1, 24),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 4),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                   : $urandom_range(1, 200),
                       1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
        end
      endcase
      sender_idles = $urandom_range(0, 2) != 0;
      receiver_stalls = $urandom_range(0, 2) != 0;
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) action = ACT_TICK;
        else if (pick < 76) action = ACT_PLAY;
        else if (pick < 92) action = ACT_SET_ONE;
        else action = ACT_SET_ALL;
        // Short intervals keep the frames moving; a few long ones cover the wide values.
        ticks = ($urandom_range(0, 15) == 0) ? TICKS_W'($urandom())
                                             : TICKS_W'($urandom_range(0, 3));
        idx = IDX_W'($urandom_range(0, 63));
        if (action == ACT_SET_ONE && $urandom_range(0, 2) == 0) idx = shown_frame;
        send_request(action, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, idx,
                     ticks);
      end
    end
  endtask

  initial begin : result_checker
    int unsigned stall;
    frame_view_t want, got;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = receiver_stalls ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      got = {playing_o, current_frame_o, texel_x_o, texel_y_o, at_first_o, at_last_o};
      if (pending_views.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_views.pop_front();
        check_field("playing", 16'(got.playing), 16'(want.playing));
        check_field("current_frame", 16'(got.frame), 16'(want.frame));
        check_field("texel_x", got.texel_x, want.texel_x);
        check_field("texel_y", got.texel_y, want.texel_y);
        check_field("at_first", 16'(got.at_first), 16'(want.at_first));
        check_field("at_last", 16'(got.at_last), 16'(want.at_last));
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    action_i         <= ACT_TICK;
    forward_i        <= 1'b0;
    force_restart_i  <= 1'b0;
    frame_index_i    <= '0;
    interval_ticks_i <= '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_FRAME_COUNT;
    cfg_data_i       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_interval_writes();
    test_forward_run();
    test_restart_rules();
    test_replay_and_pause();
    test_random_phases();

    in_valid_i <= 1'b0;
    for (int w = 0; w < 20000 && pending_views.size() != 0; w++) @(posedge clk_i);
    // Leave room for any stray result the block might still send.
    repeat (60) @(posedge clk_i);
    if (pending_views.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_views.size()));

    $display("Sent %0d requests (%0d tick, %0d play, %0d set-one, %0d set-all) over %0d layouts.",
             requests_sent, action_seen[ACT_TICK], action_seen[ACT_PLAY],
             action_seen[ACT_SET_ONE], action_seen[ACT_SET_ALL], layouts_used);
    $display("Checked %0d results field by field; %0d mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sprite_animation_frame_sequencer_top.f =====
rtl/safs_pkg.sv
rtl/safs_div.sv
rtl/safs_useq.sv
rtl/sprite_animation_frame_sequencer_top.sv
rtl/safs_chk.sv
sim/sprite_animation_frame_sequencer_top_test.sv
